[src/record_log_store_macros.svh]
// Assertion macros shared by the record log store RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef RECORD_LOG_STORE_MACROS_SVH
`define RECORD_LOG_STORE_MACROS_SVH

// ante implies cons in the same cycle
`define RLS_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("record_log_store: check failed");

// ante implies cons in the next cycle
`define RLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("record_log_store: check failed");

`endif

[src/rls_pkg.sv]
// Package for the record log store: sizes, codes, state type and address helper.
// No dependencies.
package rls_pkg;

	localparam int SLOTS        = 64;
	localparam int RECORD_WORDS = 8;
	localparam int DEPTH        = SLOTS * RECORD_WORDS;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int CS_W         = SLOT_W + 1;
	localparam int WORD_W       = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
	localparam int FILL_W       = $clog2(RECORD_WORDS + 1);

	localparam logic [15:0] ERASED     = 16'hFFFF;
	localparam logic [15:0] SIZE_BYTES = 16'(2 * RECORD_WORDS);

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_VERIFY = 2'd1;
	localparam logic [1:0] STAT_NOREC  = 2'd2;

	typedef enum logic [1:0] {
		MODE_LOCATE = 2'd0,
		MODE_STORE  = 2'd1,
		MODE_READ   = 2'd2,
		MODE_ERASE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOC_PROBE,
		S_LOC_HDR,
		S_LOC_NEXT,
		S_STORE_WR,
		S_READ_DATA,
		S_OUT
	} state_t;

	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
		return ADDR_W'(s * RECORD_WORDS);
	endfunction

endpackage

[src/record_log_store.sv]
// Record log store: append-only log of fixed-size records in one word memory.
// Store and read skip the memory access when none is needed; locate searches the slots, one probe
// per step, reading the probed slot's header and, on a match, the next slot's header through the
// one-port memory. One word in work at a time.
// Reset and erase zero a count of slots used; a slot at or past it reads erased and a per-slot
// fill count memory marks written words below it: no clearing pass. Needs rls_pkg and macros.
`include "record_log_store_macros.svh"

module record_log_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // word_data[15:0], word_sel[18:16], zero fill
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[1:0], slot[8:2], read_word[24:9], zero fill
	output logic        m_tlast    // record_done
);
	import rls_pkg::*;

	state_t state_q, state_d;

	logic signed [CS_W-1:0] cur_q;
	logic [WORD_W-1:0]      cnt_q;
	logic                   failed_q;
	logic [CS_W-1:0]        used_q;

	logic signed [CS_W-1:0] lo_q, hi_q;
	logic [SLOT_W-1:0]      mid_q;
	logic [WORD_W-1:0]      widx_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [15:0]            data_q;

	logic [1:0]  res_status_q;
	logic [15:0] res_word_q;
	logic        res_done_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [6:0]  out_slot_q;
	logic [15:0] out_word_q;
	logic        out_done_q;

	// word memory and per-slot fill counts
	logic [15:0]       mem [DEPTH];
	logic [15:0]       rdata_q;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       mem_wdata;
	logic [FILL_W-1:0] fill_mem [SLOTS];
	logic [FILL_W-1:0] fill_rd_q;
	logic              fill_we;
	logic [SLOT_W-1:0] fill_raddr;
	logic [FILL_W-1:0] fill_wdata;

	// decoded input word
	mode_t             in_mode;
	logic [15:0]       in_data;
	logic [2:0]        in_sel;
	logic              accept;

	// datapath helpers
	logic                   st_wrap, st_fail;
	logic signed [CS_W-1:0] st_slot;
	logic                   st_last;
	logic                   rd_skip;
	logic signed [CS_W-1:0] mid_c;
	logic [SLOT_W-1:0]      next_slot;
	logic [15:0]            hdr_c, nxt_c, old_c, prog_c, rword_c;
	logic [SLOT_W-1:0]      cur_idx;
	logic                   mid_used, next_used, cur_used, cur_new;
	logic                   out_load;

	assign in_mode = mode_t'(s_tuser);
	assign in_data = s_tdata[15:0];
	assign in_sel  = s_tdata[18:16];
	assign accept  = s_tvalid && s_tready;
	assign cur_idx = cur_q[SLOT_W-1:0];

	always_comb begin
		st_wrap    = (cur_q > CS_W'(SLOTS - 3));
		st_slot    = (cnt_q == '0) ? (st_wrap ? '0 : cur_q + CS_W'(1)) : cur_q;
		st_fail    = (cnt_q == '0) ? 1'b0 : failed_q;
		st_last    = (cnt_q == WORD_W'(RECORD_WORDS - 1));
		rd_skip    = (cur_q < 0) || (32'(in_sel) >= RECORD_WORDS);
		mid_c      = lo_q + ((hi_q - lo_q) >>> 1);
		next_slot  = mid_q + SLOT_W'(1);
		mid_used   = ({1'b0, mid_q} < used_q);
		next_used  = ({1'b0, next_slot} < used_q);
		cur_used   = ({1'b0, cur_idx} < used_q);
		cur_new    = ({1'b0, cur_idx} == used_q);
		hdr_c      = (mid_used && fill_rd_q != '0) ? rdata_q : ERASED;
		nxt_c      = (next_used && fill_rd_q != '0) ? rdata_q : ERASED;
		rword_c    = (cur_used && FILL_W'(widx_q) < fill_rd_q) ? rdata_q : ERASED;
		old_c      = rword_c;
		prog_c     = old_c & data_q;
		fill_wdata = FILL_W'(widx_q) + FILL_W'(1);
		out_load   = !out_valid_q || m_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_mode)
						MODE_LOCATE: state_d = S_LOC_PROBE;
						MODE_STORE:  state_d = st_fail ? S_OUT : S_STORE_WR;
						MODE_READ:   state_d = rd_skip ? S_OUT : S_READ_DATA;
						MODE_ERASE:  state_d = S_OUT;
					endcase
				end
			end
			S_LOC_PROBE: state_d = (hi_q < lo_q) ? S_OUT : S_LOC_HDR;
			S_LOC_HDR:   state_d = (hdr_c == SIZE_BYTES) ? S_LOC_NEXT : S_LOC_PROBE;
			S_LOC_NEXT:  state_d = (nxt_c == ERASED) ? S_OUT : S_LOC_PROBE;
			S_STORE_WR:  state_d = S_OUT;
			S_READ_DATA: state_d = S_OUT;
			S_OUT:       state_d = out_load ? S_IDLE : S_OUT;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory control and handshake
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		mem_re     = 1'b0;
		mem_raddr  = '0;
		mem_we     = 1'b0;
		mem_wdata  = prog_c;
		fill_we    = 1'b0;
		fill_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_mode == MODE_STORE) begin
					mem_re     = 1'b1;
					mem_raddr  = slot_base(st_slot[SLOT_W-1:0]) + ADDR_W'(cnt_q);
					fill_raddr = st_slot[SLOT_W-1:0];
				end else if (accept && in_mode == MODE_READ) begin
					mem_re     = 1'b1;
					mem_raddr  = slot_base(cur_idx) + ADDR_W'(WORD_W'(in_sel));
					fill_raddr = cur_idx;
				end
			end
			S_LOC_PROBE: begin
				mem_re     = 1'b1;
				mem_raddr  = slot_base(mid_c[SLOT_W-1:0]);
				fill_raddr = mid_c[SLOT_W-1:0];
			end
			S_LOC_HDR: begin
				mem_re     = 1'b1;
				mem_raddr  = slot_base(next_slot);
				fill_raddr = next_slot;
			end
			S_STORE_WR: begin
				mem_we = 1'b1;
				// word index never runs ahead of the fill count
				fill_we = cur_new || (cur_used && FILL_W'(widx_q) == fill_rd_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr_q] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
		if (fill_we)
			fill_mem[cur_idx] <= fill_wdata;
		if (mem_re)
			fill_rd_q <= fill_mem[fill_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '1;
			cnt_q    <= '0;
			failed_q <= 1'b0;
			used_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= STAT_OK;
						res_word_q   <= '0;
						res_done_q   <= 1'b0;
						data_q       <= in_data;
						unique case (in_mode)
							MODE_LOCATE: begin
								cnt_q    <= '0;
								failed_q <= 1'b0;
								lo_q     <= '0;
								hi_q     <= CS_W'(SLOTS - 2);
							end
							MODE_STORE: begin
								// first word: advance the slot, wrap with a full erase
								if (cnt_q == '0) begin
									if (st_wrap)
										used_q <= '0;
									failed_q <= 1'b0;
								end
								cur_q  <= st_slot;
								widx_q <= cnt_q;
								addr_q <= mem_raddr;
								cnt_q  <= st_last ? '0 : cnt_q + WORD_W'(1);
								res_done_q <= st_last;
								if (st_fail)
									res_status_q <= STAT_VERIFY;
							end
							MODE_READ: begin
								widx_q <= WORD_W'(in_sel);
								if (cur_q < 0)
									res_status_q <= STAT_NOREC;
							end
							MODE_ERASE: begin
								used_q   <= '0;
								cur_q    <= '1;
								cnt_q    <= '0;
								failed_q <= 1'b0;
							end
						endcase
					end
				end
				S_LOC_PROBE: begin
					if (hi_q < lo_q) begin
						cur_q        <= '1;
						res_status_q <= STAT_NOREC;
					end else begin
						mid_q <= mid_c[SLOT_W-1:0];
					end
				end
				S_LOC_HDR: begin
					if (hdr_c != SIZE_BYTES)
						hi_q <= $signed({1'b0, mid_q}) - CS_W'(1);
				end
				S_LOC_NEXT: begin
					if (nxt_c == ERASED)
						cur_q <= $signed({1'b0, mid_q});
					else
						lo_q <= $signed({1'b0, next_slot});
				end
				S_STORE_WR: begin
					// first touch of a slot since the last erase
					if (cur_new)
						used_q <= used_q + CS_W'(1);
					if (prog_c != data_q) begin
						failed_q     <= 1'b1;
						res_status_q <= STAT_VERIFY;
					end
				end
				S_READ_DATA: res_word_q <= rword_c;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_slot_q   <= 7'(cur_q);
				out_word_q   <= res_word_q;
				out_done_q   <= res_done_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_word_q, out_slot_q, out_status_q};
	assign m_tlast  = out_done_q;

	`RLS_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_q != S_IDLE)
	`RLS_ASSERT_HOLDS(a_done_not_norec, m_tvalid && m_tlast, m_tdata[1:0] != STAT_NOREC)
	`RLS_ASSERT_HOLDS(a_slot_range, state_q == S_IDLE, cur_q >= -1 && cur_q <= SLOTS - 1)

endmodule
